/* src/rvb_pkg.sv */
// ----------------------------------------------------------------------------
// rvb_pkg
// Shared types and constants of the relay volume and balance controller.
// ----------------------------------------------------------------------------
package rvb_pkg;

  // Range limits of the volume and balance controls
  localparam logic [6:0]        MAX_VOLUME  = 7'd64;
  localparam logic signed [4:0] MAX_BALANCE = 5'sd9;

  // Power level at which events act
  localparam logic [1:0] POWER_FULL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_POWER_LEVEL     = 2'd0;
  localparam logic [1:0] CFG_BALANCE_ENABLED = 2'd1;

  // Event kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_VOLUME  = 2'd0,
    OP_BALANCE = 2'd1,
    OP_MUTE    = 2'd2,
    OP_UNMUTE  = 2'd3
  } rvb_op_t;

  // Controller state kept between events
  typedef struct packed {
    logic [6:0]        volume;
    logic signed [4:0] balance;
    logic signed [1:0] volume_carry;
    logic signed [1:0] balance_carry;
    logic              muted;
    logic [5:0]        prev_left;
    logic [5:0]        prev_right;
  } rvb_state_t;

  // Up to two relay words caused by one event, with the status after it
  typedef struct packed {
    logic              two;
    logic [5:0]        mid_left;
    logic [5:0]        mid_right;
    logic [5:0]        fin_left;
    logic [5:0]        fin_right;
    logic [6:0]        volume;
    logic signed [4:0] balance;
    logic              muted;
  } rvb_words_t;

endpackage

/* src/rvb_step.sv */
// ----------------------------------------------------------------------------
// rvb_step
// Single-pass event logic: pulse accumulation, saturation, balance split,
// code derivation and anti-click check for one registered event.
// ----------------------------------------------------------------------------
module rvb_step
  import rvb_pkg::*;
(
  input  rvb_state_t        st,
  input  rvb_op_t           op,
  input  logic signed [4:0] delta,
  input  logic [1:0]        power_level,
  input  logic              balance_enabled,
  output rvb_state_t        st_next,
  output logic              has_result,
  output rvb_words_t        words
);

  logic              active;
  logic              is_vol;
  logic              vol_ev;
  logic              bal_ev;
  logic              mute_ev;
  logic              codes_ev;
  logic signed [4:0] eff_delta;
  logic signed [1:0] carry_in;
  logic signed [5:0] pulse_sum;
  logic signed [5:0] sum_adj;
  logic signed [5:0] half;
  logic signed [4:0] steps;
  logic signed [5:0] rem6;
  logic signed [8:0] vol_sum;
  logic [6:0]        vol_new;
  logic signed [5:0] bal_sum;
  logic signed [4:0] bal_new;
  logic [6:0]        nv;
  logic signed [4:0] nb;
  logic              nm;
  logic signed [4:0] br;
  logic signed [8:0] lvl_r;
  logic signed [8:0] lvl_l;
  logic [6:0]        clr;
  logic [6:0]        cll;
  logic [5:0]        cr;
  logic [5:0]        cl;
  logic [5:0]        ml;
  logic [5:0]        mr;
  logic              zero_codes;
  logic              update;
  logic              click;

  // Decode the event
  assign active  = (power_level == POWER_FULL);
  assign is_vol  = (op == OP_VOLUME) || (op == OP_UNMUTE);
  assign vol_ev  = active && is_vol;
  assign bal_ev  = active && (op == OP_BALANCE) && !st.muted && balance_enabled;
  assign mute_ev = active && (op == OP_MUTE);
  assign codes_ev = vol_ev || bal_ev;

  // Unmute and pulses while muted carry no pulses
  assign eff_delta = (is_vol && ((op == OP_UNMUTE) || st.muted)) ? 5'sd0 : delta;
  assign carry_in  = is_vol ? st.volume_carry : st.balance_carry;

  // Two pulses make one step; quotient truncates toward zero
  assign pulse_sum = {{4{carry_in[1]}}, carry_in} + {eff_delta[4], eff_delta};
  assign sum_adj   = pulse_sum + {5'b0, pulse_sum[5]};
  assign half      = sum_adj >>> 1;
  assign steps     = half[4:0];
  assign rem6      = pulse_sum - (half <<< 1);

  // Saturate volume to 0..MAX_VOLUME
  assign vol_sum = $signed({2'b00, st.volume}) + {{4{steps[4]}}, steps};
  always_comb begin
    if (vol_sum < 9'sd0) begin
      vol_new = 7'd0;
    end else if (vol_sum > $signed({2'b00, MAX_VOLUME})) begin
      vol_new = MAX_VOLUME;
    end else begin
      vol_new = vol_sum[6:0];
    end
  end

  // Saturate balance to -MAX_BALANCE..MAX_BALANCE
  assign bal_sum = {st.balance[4], st.balance} + {steps[4], steps};
  always_comb begin
    if (bal_sum > $signed({MAX_BALANCE[4], MAX_BALANCE})) begin
      bal_new = MAX_BALANCE;
    end else if (bal_sum < -$signed({MAX_BALANCE[4], MAX_BALANCE})) begin
      bal_new = -MAX_BALANCE;
    end else begin
      bal_new = bal_sum[4:0];
    end
  end

  // Control values after the event
  assign nv = vol_ev ? vol_new : st.volume;
  assign nb = bal_ev ? bal_new : st.balance;
  assign nm = mute_ev ? 1'b1 : (vol_ev ? 1'b0 : st.muted);

  // Split balance into right and left offsets
  assign br    = nb >>> 1;
  assign lvl_r = balance_enabled ? ($signed({2'b00, nv}) + {{4{br[4]}}, br})
                                 : $signed({2'b00, nv});
  assign lvl_l = balance_enabled ? (lvl_r - {{4{nb[4]}}, nb}) : $signed({2'b00, nv});

  // Clamp each channel level
  always_comb begin
    if (lvl_r < 9'sd0) begin
      clr = 7'd0;
    end else if (lvl_r > $signed({2'b00, MAX_VOLUME})) begin
      clr = MAX_VOLUME;
    end else begin
      clr = lvl_r[6:0];
    end
    if (lvl_l < 9'sd0) begin
      cll = 7'd0;
    end else if (lvl_l > $signed({2'b00, MAX_VOLUME})) begin
      cll = MAX_VOLUME;
    end else begin
      cll = lvl_l[6:0];
    end
  end

  // Lower each nonzero level by one to get the relay word
  assign cr = (clr != 7'd0) ? 6'(clr - 7'd1) : 6'd0;
  assign cl = (cll != 7'd0) ? 6'(cll - 7'd1) : 6'd0;

  // Anti-click: send the AND of old and new words first when needed
  assign ml    = st.prev_left & cl;
  assign mr    = st.prev_right & cr;
  assign click = ((ml != st.prev_left) && (ml != cl)) ||
                 ((mr != st.prev_right) && (mr != cr));

  assign zero_codes = (nv == 7'd0) || nm;
  assign update     = codes_ev && !zero_codes;

  // Next state
  always_comb begin
    st_next               = st;
    st_next.volume        = nv;
    st_next.balance       = nb;
    st_next.muted         = nm;
    if (vol_ev) begin
      st_next.volume_carry = rem6[1:0];
    end
    if (bal_ev) begin
      st_next.balance_carry = rem6[1:0];
    end
    if (update) begin
      st_next.prev_left  = cl;
      st_next.prev_right = cr;
    end
  end

  // Result words
  assign has_result      = mute_ev || codes_ev;
  assign words.two       = update && click;
  assign words.mid_left  = ml;
  assign words.mid_right = mr;
  assign words.fin_left  = update ? cl : 6'd0;
  assign words.fin_right = update ? cr : 6'd0;
  assign words.volume    = nv;
  assign words.balance   = nb;
  assign words.muted     = nm;

endmodule

/* src/rvb_out_stage.sv */
// ----------------------------------------------------------------------------
// rvb_out_stage
// Result register: holds the words of one event and sends the intermediate
// anti-click word before the final one.
// ----------------------------------------------------------------------------
module rvb_out_stage
  import rvb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  rvb_words_t  load_words,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  logic       busy;
  logic       pending_mid;
  rvb_words_t words;
  logic [5:0] left_code;
  logic [5:0] right_code;

  // Space for a new event once the final word leaves
  assign free = !busy || (m_tready && !pending_mid);

  // Hold, advance or drop the stored words
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pending_mid <= 1'b0;
    end else if (load) begin
      busy        <= 1'b1;
      pending_mid <= load_words.two;
    end else if (busy && m_tready) begin
      if (pending_mid) begin
        pending_mid <= 1'b0;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words <= load_words;
    end
  end

  // Select the word on the bus
  assign left_code  = pending_mid ? words.mid_left : words.fin_left;
  assign right_code = pending_mid ? words.mid_right : words.fin_right;

  assign m_tvalid = busy;
  assign m_tlast  = !pending_mid;
  assign m_tdata  = {7'b0, words.muted, words.balance, words.volume, right_code, left_code};

endmodule

/* src/relay_volume_balance_controller_unit.sv */
// ----------------------------------------------------------------------------
// relay_volume_balance_controller_unit
// Turns knob pulse and mute events into left and right relay attenuator words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one event per transfer. tuser = opcode (0 volume pulses,
//   1 balance pulses, 2 mute, 3 unmute); tdata = signed pulse count.
//   Output channel m_*: relay words. tlast is low on an intermediate anti-click
//   word (let the relays settle before applying the next) and high on the
//   final word of an event. tdata also reports volume, balance and mute state.
//   Config channel cfg_*: index 0 power level (events act only at level 2),
//   index 1 balance enable. Always ready; write only while the block is idle.
// Timing:
//   An event is registered at the input, worked out in one pass and loaded
//   into the result register once that register is free; its first word is
//   then on m_*. One event per cycle is taken while each event yields one
//   word and m_tready is high; an anti-click event holds the result register
//   for both its words. Events that yield no word never wait for it.
// Reset and stalls:
//   rst clears volume, balance, carries, mute and the anti-click history,
//   sets power level 0 and balance enabled. When m_tready is low the result
//   is held and the input register fills, then s_tready drops.
// ----------------------------------------------------------------------------
module relay_volume_balance_controller_unit
  import rvb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Event input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] pulse_delta, [7:5] zero
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // Relay word output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [5:0] left_code, [11:6] right_code,
                                 // [18:12] volume_now, [23:19] balance_now,
                                 // [24] muted_now, [31:25] zero
  output logic        m_tlast,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  logic              in_vld;
  rvb_op_t           in_op;
  logic signed [4:0] in_delta;
  logic [1:0]        power_level;
  logic              balance_enabled;
  rvb_state_t        st;
  rvb_state_t        st_next;
  logic              has_result;
  rvb_words_t        words;
  logic              out_free;
  logic              consume;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_level     <= 2'd0;
      balance_enabled <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POWER_LEVEL:     power_level     <= cfg_data;
        CFG_BALANCE_ENABLED: balance_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register advances when its event moves on
  assign consume  = in_vld && (!has_result || out_free);
  assign s_tready = !in_vld || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (consume) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op    <= rvb_op_t'(s_tuser);
      in_delta <= s_tdata[4:0];
    end
  end

  // Event logic
  rvb_step u_step (
    .st              (st),
    .op              (in_op),
    .delta           (in_delta),
    .power_level     (power_level),
    .balance_enabled (balance_enabled),
    .st_next         (st_next),
    .has_result      (has_result),
    .words           (words)
  );

  // Controller state commits when the event is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (consume) begin
      st <= st_next;
    end
  end

  // Result register
  rvb_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (consume && has_result),
    .load_words (words),
    .free       (out_free),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

/* bench/tb_relay_volume_balance_controller_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_relay_volume_balance_controller_unit
// Self-checking bench for the relay volume and balance controller. A built-in
// predictor tracks volume, balance, pulse carries, mute and the anti-click
// history, and queues the relay words each event should produce. A directed
// pass covers power gating, range limits, muting and single-ended mode.
// Random traffic follows, under changing stall patterns and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_relay_volume_balance_controller_unit;
  import rvb_pkg::*;

  // Power levels other than full power
  localparam logic [1:0] POWER_OFF     = 2'd0;
  localparam logic [1:0] POWER_STANDBY = 2'd1;
  localparam logic [1:0] POWER_SPARE   = 2'd3;

  // Register indexes with no register behind them
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  // Pulse counts used by the directed tests
  localparam logic [4:0] PULSE_MAX  = 5'b01111;
  localparam logic [4:0] PULSE_MIN  = 5'b10000;
  localparam logic [4:0] PULSE_UP1  = 5'b00001;
  localparam logic [4:0] PULSE_UP4  = 5'b00100;
  localparam logic [4:0] PULSE_DN3  = 5'b11101;
  localparam logic [4:0] PULSE_ZERO = 5'b00000;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 4000;

  // Shape of the random knob pulses within one chunk of events
  typedef enum logic [1:0] {
    DRIFT_ANY  = 2'd0,
    DRIFT_FINE = 2'd1,
    DRIFT_UP   = 2'd2,
    DRIFT_DOWN = 2'd3
  } drift_t;

  // One relay word as it should appear on the output
  typedef struct packed {
    logic [5:0]        left_code;
    logic [5:0]        right_code;
    logic              last_flag;
    logic [6:0]        volume_now;
    logic signed [4:0] balance_now;
    logic              muted_now;
  } relay_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [1:0]  cfg_data = '0;

  // Predicted controller state and registers
  logic [1:0]        power_level;
  logic              balance_on;
  logic [6:0]        volume_level;
  logic signed [4:0] balance_level;
  int                volume_pulses;
  int                balance_pulses;
  logic              muted_flag;
  logic [5:0]        last_left;
  logic [5:0]        last_right;
  relay_word_t       expected_words[$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_request = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  relay_volume_balance_controller_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Queue a relay word tagged with the status after the event
  task automatic queue_word(input logic [5:0] left, input logic [5:0] right,
                            input logic last);
    relay_word_t w;
    w.left_code   = left;
    w.right_code  = right;
    w.last_flag   = last;
    w.volume_now  = volume_level;
    w.balance_now = balance_level;
    w.muted_now   = muted_flag;
    expected_words.push_back(w);
  endtask

  function automatic int clamp_level(input int v);
    if (v > int'(MAX_VOLUME)) return int'(MAX_VOLUME);
    if (v < 0) return 0;
    return v;
  endfunction

  // Add pulses to the carry; every two pulses move the value one saturating step
  task automatic step_pulses(inout int carry, inout int value, input int lo,
                             input int hi, input int delta);
    carry += delta;
    while (carry >= 2) begin
      if (value < hi) value++;
      carry -= 2;
    end
    while (carry <= -2) begin
      if (value > lo) value--;
      carry += 2;
    end
  endtask

  // Work out the relay codes, with an anti-click word first when needed
  task automatic drive_relays();
    int vol, bal, shift_r, lvl_l, lvl_r;
    logic [5:0] code_l, code_r, mid_l, mid_r;
    logic click;
    vol = volume_level;
    bal = balance_level;
    if (vol == 0 || muted_flag) begin
      // silent output leaves the anti-click history alone
      queue_word('0, '0, 1'b1);
    end else begin
      if (balance_on) begin
        // right offset rounds toward minus infinity
        shift_r = bal >>> 1;
        lvl_r = clamp_level(vol + shift_r);
        lvl_l = clamp_level(vol + shift_r - bal);
      end else begin
        lvl_r = vol;
        lvl_l = vol;
      end
      if (lvl_r > 0) lvl_r--;
      if (lvl_l > 0) lvl_l--;
      code_l = lvl_l[5:0];
      code_r = lvl_r[5:0];
      mid_l = last_left & code_l;
      mid_r = last_right & code_r;
      click = (mid_l != last_left && mid_l != code_l) ||
              (mid_r != last_right && mid_r != code_r);
      last_left = code_l;
      last_right = code_r;
      if (click) queue_word(mid_l, mid_r, 1'b0);
      queue_word(code_l, code_r, 1'b1);
    end
  endtask

  // Update the state for one accepted event and queue its relay words
  task automatic predict_event(input rvb_op_t op, input logic [4:0] pulse);
    int delta, v;
    delta = $signed(pulse);
    if (power_level == POWER_FULL) begin
      case (op)
        OP_VOLUME, OP_UNMUTE: begin
          // unmute, or pulses while muted, only lift the mute
          if (op == OP_UNMUTE || muted_flag) delta = 0;
          muted_flag = 1'b0;
          v = volume_level;
          step_pulses(volume_pulses, v, 0, int'(MAX_VOLUME), delta);
          volume_level = v[6:0];
          drive_relays();
        end
        OP_BALANCE: begin
          if (!muted_flag && balance_on) begin
            v = balance_level;
            step_pulses(balance_pulses, v, -int'(MAX_BALANCE), int'(MAX_BALANCE),
                        delta);
            balance_level = v[4:0];
            drive_relays();
          end
        end
        default: begin
          muted_flag = 1'b1;
          queue_word('0, '0, 1'b1);
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one event, idling at random first, and predict it on transfer
  task automatic send_event(input rvb_op_t op, input logic [4:0] pulse);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, pulse};
    do @(posedge clk); while (!s_tready);
    predict_event(op, pulse);
  endtask

  // Stop offering, wait for every queued word, then let dropped events drain
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      CFG_POWER_LEVEL:     power_level = value;
      CFG_BALANCE_ENABLED: balance_on = value[0];
      default: ;
    endcase
  endtask

  function automatic rvb_op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 40) return OP_VOLUME;
    if (r < 75) return OP_BALANCE;
    if (r < 87) return OP_MUTE;
    return OP_UNMUTE;
  endfunction

  function automatic logic [4:0] pick_pulse(input drift_t drift);
    int t;
    case (drift)
      DRIFT_ANY:  t = $urandom_range(31);
      DRIFT_FINE: t = int'($urandom_range(4)) - 2;
      DRIFT_UP:   t = $urandom_range(15);
      default:    t = -1 - int'($urandom_range(15));
    endcase
    return t[4:0];
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Events below full power and writes to spare indexes change nothing
  task automatic test_power_gating();
    send_event(OP_VOLUME, PULSE_MAX);
    send_event(OP_BALANCE, PULSE_MIN);
    send_event(OP_MUTE, PULSE_ZERO);
    send_event(OP_UNMUTE, PULSE_MAX);
    write_register(CFG_POWER_LEVEL, POWER_STANDBY);
    send_event(OP_VOLUME, PULSE_MAX);
    send_event(OP_UNMUTE, PULSE_ZERO);
    write_register(CFG_POWER_LEVEL, POWER_SPARE);
    send_event(OP_VOLUME, PULSE_MAX);
    send_event(OP_MUTE, PULSE_MIN);
    write_register(CFG_SPARE_A, 2'd3);
    write_register(CFG_SPARE_B, 2'd2);
    send_event(OP_VOLUME, PULSE_MAX);
    write_register(CFG_POWER_LEVEL, POWER_FULL);
    write_register(CFG_SPARE_B, 2'd0);
  endtask

  // Half steps, climb to the top and saturate, come back down
  task automatic test_volume_range();
    send_event(OP_VOLUME, PULSE_UP1);
    send_event(OP_VOLUME, PULSE_UP1);
    repeat (9) send_event(OP_VOLUME, PULSE_MAX);
    send_event(OP_VOLUME, PULSE_MIN);
    send_event(OP_VOLUME, PULSE_ZERO);
  endtask

  // Saturate the balance at both ends
  task automatic test_balance_range();
    repeat (2) send_event(OP_BALANCE, PULSE_MAX);
    repeat (3) send_event(OP_BALANCE, PULSE_MIN);
  endtask

  // Mute, ignored balance while muted, unmute by knob and by button
  task automatic test_mute_handling();
    send_event(OP_MUTE, PULSE_ZERO);
    send_event(OP_BALANCE, PULSE_UP4);
    send_event(OP_VOLUME, PULSE_MAX);
    send_event(OP_MUTE, PULSE_MAX);
    send_event(OP_UNMUTE, PULSE_MIN);
    send_event(OP_MUTE, PULSE_ZERO);
    send_event(OP_MUTE, PULSE_ZERO);
  endtask

  // Balance disabled: both channels follow the volume, balance events dropped
  task automatic test_single_ended();
    write_register(CFG_BALANCE_ENABLED, 2'd2);
    send_event(OP_VOLUME, PULSE_DN3);
    send_event(OP_BALANCE, PULSE_MAX);
    send_event(OP_UNMUTE, PULSE_ZERO);
    write_register(CFG_BALANCE_ENABLED, 2'd3);
    send_event(OP_VOLUME, PULSE_ZERO);
  endtask

  // Random events, with the pulse shape changing every chunk
  task automatic test_random_traffic(input int count, input int src_pct,
                                     input int snk_pct);
    drift_t drift;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    drift = DRIFT_ANY;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) drift = drift_t'($urandom_range(3));
      send_event(pick_op(), pick_pulse(drift));
    end
  endtask

  // Hold the output off while events keep coming, so the input stalls
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_event(pick_op(), pick_pulse(DRIFT_ANY));
    drain();
  endtask

  // Traffic below full power is taken and dropped
  task automatic test_standby_drop();
    write_register(CFG_POWER_LEVEL, POWER_STANDBY);
    test_random_traffic(20, 14, 83);
    write_register(CFG_POWER_LEVEL, POWER_FULL);
  endtask

  // --------------------------------------------------------------------------
  // Output side: stall at random, check every word
  // --------------------------------------------------------------------------

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  initial begin : relay_sink
    int hold_left;
    relay_word_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected relay word, expected none actual %h tlast %b",
                   $time, m_tdata, m_tlast);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("left_code", want.left_code, m_tdata[5:0]);
          check_field("right_code", want.right_code, m_tdata[11:6]);
          check_field("last", want.last_flag, m_tlast);
          check_field("volume_now", want.volume_now, m_tdata[18:12]);
          check_field("balance_now", want.balance_now, $signed(m_tdata[23:19]));
          check_field("muted_now", want.muted_now, m_tdata[24]);
        end
      end
      // take a hold-off request, then stall for its length
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Abort when no transfer happens on any channel for too long
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[relay_volume_balance_controller_unit] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    power_level    = POWER_OFF;
    balance_on     = 1'b1;
    volume_level   = '0;
    balance_level  = '0;
    volume_pulses  = 0;
    balance_pulses = 0;
    muted_flag     = 1'b0;
    last_left      = '0;
    last_right     = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_power_gating();
    test_volume_range();
    test_balance_range();
    test_mute_handling();
    test_single_ended();
    test_random_traffic(380, 14, 83);
    test_backpressure();
    test_standby_drop();
    write_register(CFG_BALANCE_ENABLED, 2'd0);
    test_random_traffic(150, 83, 14);
    write_register(CFG_BALANCE_ENABLED, 2'd1);
    test_random_traffic(230, 83, 14);
    test_random_traffic(290, 0, 0);
    drain();

    if (mismatch_count == 0) begin
      $display("[relay_volume_balance_controller_unit] OK");
    end else begin
      $display("[relay_volume_balance_controller_unit] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
src/rvb_pkg.sv
src/rvb_step.sv
src/rvb_out_stage.sv
src/relay_volume_balance_controller_unit.sv
bench/tb_relay_volume_balance_controller_unit.sv
